// ===== rtl/core/tnb_pkg.sv =====
package tnb_pkg;

  localparam int COORD_W = 32;
  localparam int CROSS_W = 67;
  localparam int UVAL_W = 31;
  localparam int SUM_W = 64;
  localparam int LEN_W = 32;
  localparam int COUNT_W = 24;
  localparam int THRESH_W = 16;
  localparam int INDEX_W = 26;
  localparam int NORMAL_W = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TRIANGLES = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_NORMAL_LENGTH = 1'b1;

  localparam logic [1:0] STATUS_APPENDED = 2'd0;
  localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_CHECK,
    ST_SUMSQ,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

  // control between sequencer and shared arithmetic unit
  typedef struct packed {
    logic sqrt_start;
    logic div_start;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/core/tnb_unit.sv =====
// Shared bit-serial unit: integer square root of a 64-bit sum, or
// restoring division (num / den), one result bit per cycle.
module tnb_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  tnb_pkg::unit_ctrl_t           ctrl,
  input  logic [tnb_pkg::SUM_W-1:0]     sqrt_in,
  input  logic [tnb_pkg::SUM_W-1:0]     num_in,
  input  logic [tnb_pkg::LEN_W-1:0]     den_in,
  output tnb_pkg::unit_stat_t           stat,
  output logic [tnb_pkg::SUM_W-1:0]     result
);
  import tnb_pkg::*;

  localparam int CNT_W = 7;

  logic              is_sqrt;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [SUM_W+1:0]  rem;
  logic [SUM_W-1:0]  src;
  logic [SUM_W-1:0]  root;
  logic [LEN_W-1:0]  den;
  logic [SUM_W+1:0]  trial;
  logic [SUM_W+1:0]  rem_sh;

  always_comb begin
    if (is_sqrt) begin
      rem_sh = {rem[SUM_W-1:0], src[SUM_W-1 -: 2]};
      trial = rem_sh - {root[SUM_W-1:0], 2'b01};
    end else begin
      rem_sh = {rem[SUM_W:0], src[SUM_W-1]};
      trial = rem_sh - {{(SUM_W+2-LEN_W){1'b0}}, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      is_sqrt <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.sqrt_start || ctrl.div_start) begin
        busy <= 1'b1;
        is_sqrt <= ctrl.sqrt_start;
        cnt <= ctrl.sqrt_start ? CNT_W'(SUM_W / 2) : CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sqrt_start || ctrl.div_start) begin
      rem <= '0;
      root <= '0;
      src <= ctrl.sqrt_start ? sqrt_in : num_in;
      den <= den_in;
    end else if (busy) begin
      if (is_sqrt) src <= {src[SUM_W-3:0], 2'b00};
      else src <= {src[SUM_W-2:0], 1'b0};
      if (!trial[SUM_W+1]) begin
        rem <= trial;
        root <= {root[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result = root;

endmodule

// ===== rtl/core/triangle_normal_and_bounds.sv =====
// Triangle face normal and running bounding box. Each item is one triangle
// (three Q16.16 corners); the block returns one result item per triangle
// with a status (appended, degenerate, rejected at the limit), the unit
// normal in Q1.14, three times the prior triangle count, and the running
// box. An appended item passes through the cross products on a shared
// 33x33 multiplier, the degeneracy check, the sum of squares on the same
// multiplier, the square root and three divides on one shared bit-serial
// unit, and a publish step. A degenerate item stops after the check and a
// rejected one goes straight to publish. in_ready is low while an item is
// in work or its result waits, so the next item is accepted only once the
// result has been taken. Configuration is written through
// cfg_we/cfg_addr/cfg_data.
module triangle_normal_and_bounds (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tnb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tnb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            a_x,
  input  logic signed [31:0]            a_y,
  input  logic signed [31:0]            a_z,
  input  logic signed [31:0]            b_x,
  input  logic signed [31:0]            b_y,
  input  logic signed [31:0]            b_z,
  input  logic signed [31:0]            c_x,
  input  logic signed [31:0]            c_y,
  input  logic signed [31:0]            c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic signed [15:0]            normal_x,
  output logic signed [15:0]            normal_y,
  output logic signed [15:0]            normal_z,
  output logic [25:0]                   first_index,
  output logic signed [31:0]            box_min_x,
  output logic signed [31:0]            box_min_y,
  output logic signed [31:0]            box_min_z,
  output logic signed [31:0]            box_max_x,
  output logic signed [31:0]            box_max_y,
  output logic signed [31:0]            box_max_z
);
  import tnb_pkg::*;

  localparam logic [SUM_W-1:0] ONE_Q = SUM_W'(1) << NORMAL_FRAC_BITS;

  state_t state, state_next;

  logic [COUNT_W-1:0]  max_triangles;
  logic [THRESH_W-1:0] min_normal_length;
  logic [COUNT_W-1:0]  triangle_count;
  logic                box_valid;
  logic signed [COORD_W-1:0] bmin [3];
  logic signed [COORD_W-1:0] bmax [3];
  logic signed [COORD_W-1:0] pt [3][3];

  // edge vectors, cross accumulators
  logic signed [COORD_W:0] e [3];
  logic signed [COORD_W:0] f [3];
  logic signed [CROSS_W-1:0] cr [3];
  logic [3:0] step;

  logic [CROSS_W-1:0] mag [3];
  logic [2:0] neg;
  logic [UVAL_W-1:0] u [3];
  logic [SUM_W-1:0] sum;
  logic [LEN_W-1:0] len;
  logic [1:0] dj;
  logic signed [NORMAL_W-1:0] nrm [3];

  // shared multiplier, one product a cycle
  logic signed [COORD_W:0] mul_a, mul_b;
  logic signed [2*COORD_W+1:0] prod;
  logic [1:0] sel_c;
  logic sub_p;
  logic [UVAL_W-1:0] sq_op;

  unit_ctrl_t uctrl;
  unit_stat_t ustat;
  logic [SUM_W-1:0] u_res;

  // top bit position over the three magnitudes
  logic [CROSS_W-1:0] mor;
  logic [6:0] top;
  logic [6:0] shamt;
  logic tiny_cross;
  logic [2*THRESH_W+1:0] sq_small;
  logic [SUM_W-1:0] q;

  always_comb begin
    // cross: step 0..5 products e1f2, e2f1, e2f0, e0f2, e0f1, e1f0
    // sum of squares: step 0..2 squares u0, u1, u2
    mul_a = e[0];
    mul_b = f[0];
    sel_c = 2'd0;
    sub_p = 1'b0;
    sq_op = u[2];
    if (state == ST_SUMSQ) begin
      case (step[1:0])
        2'd0: sq_op = u[0];
        2'd1: sq_op = u[1];
        default: sq_op = u[2];
      endcase
      mul_a = $signed({2'b00, sq_op});
      mul_b = $signed({2'b00, sq_op});
    end else begin
      case (step[2:0])
        3'd0: begin mul_a = e[1]; mul_b = f[2]; sel_c = 2'd0; sub_p = 1'b0; end
        3'd1: begin mul_a = e[2]; mul_b = f[1]; sel_c = 2'd0; sub_p = 1'b1; end
        3'd2: begin mul_a = e[2]; mul_b = f[0]; sel_c = 2'd1; sub_p = 1'b0; end
        3'd3: begin mul_a = e[0]; mul_b = f[2]; sel_c = 2'd1; sub_p = 1'b1; end
        3'd4: begin mul_a = e[0]; mul_b = f[1]; sel_c = 2'd2; sub_p = 1'b0; end
        default: begin mul_a = e[1]; mul_b = f[0]; sel_c = 2'd2; sub_p = 1'b1; end
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    mor = mag[0] | mag[1] | mag[2];
    top = '0;
    for (int i = 0; i < CROSS_W; i++) begin
      if (mor[i]) top = 7'(i + 1);
    end
    shamt = (top > 7'd31) ? top - 7'd31 : 7'd0;
    tiny_cross = (mor[CROSS_W-1:THRESH_W] == '0);
    sq_small = 34'(mag[0][15:0] * mag[0][15:0]) + 34'(mag[1][15:0] * mag[1][15:0])
             + 34'(mag[2][15:0] * mag[2][15:0]);
  end

  assign q = (u_res > ONE_Q) ? ONE_Q : u_res;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && in_ready) begin
        state_next = (triangle_count >= max_triangles) ? ST_DONE : ST_CROSS;
      end
      ST_CROSS: if (step == 4'd6) state_next = ST_CHECK;
      ST_CHECK: begin
        if (tiny_cross && sq_small <= 34'(min_normal_length * min_normal_length))
          state_next = ST_DONE;
        else state_next = ST_SUMSQ;
      end
      ST_SUMSQ: if (step == 4'd3) state_next = ST_SQRT;
      ST_SQRT: if (ustat.done) state_next = ST_DIV;
      ST_DIV: if (ustat.done && dj == 2'd2) state_next = ST_DONE;
      ST_DONE: if (!out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // unit starts
  always_comb begin
    uctrl.sqrt_start = (state == ST_SUMSQ) && (step == 4'd3);
    uctrl.div_start = ((state == ST_SQRT) && ustat.done)
                   || ((state == ST_DIV) && ustat.done && dj != 2'd2);
  end

  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      max_triangles <= COUNT_W'(10000000);
      min_normal_length <= '0;
      triangle_count <= '0;
      box_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        bmin[j] <= '0;
        bmax[j] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MAX_TRIANGLES: max_triangles <= cfg_data;
          REG_MIN_NORMAL_LENGTH: min_normal_length <= cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      // publish result; fold box for appended items
      if (state == ST_DONE && !out_valid) begin
        out_valid <= 1'b1;
        if (status == STATUS_APPENDED) begin
          triangle_count <= triangle_count + 1'b1;
          box_valid <= 1'b1;
          for (int j = 0; j < 3; j++) begin
            logic signed [COORD_W-1:0] mn, mx;
            mn = box_valid ? bmin[j] : pt[0][j];
            mx = box_valid ? bmax[j] : pt[0][j];
            for (int i = 0; i < 3; i++) begin
              if (pt[i][j] < mn) mn = pt[i][j];
              if (pt[i][j] > mx) mx = pt[i][j];
            end
            bmin[j] <= mn;
            bmax[j] <= mx;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // load only on acceptance; hold the previous result otherwise
        if (in_valid && in_ready) begin
          pt[0][0] <= a_x; pt[0][1] <= a_y; pt[0][2] <= a_z;
          pt[1][0] <= b_x; pt[1][1] <= b_y; pt[1][2] <= b_z;
          pt[2][0] <= c_x; pt[2][1] <= c_y; pt[2][2] <= c_z;
          e[0] <= 33'(b_x) - 33'(a_x);
          e[1] <= 33'(b_y) - 33'(a_y);
          e[2] <= 33'(b_z) - 33'(a_z);
          f[0] <= 33'(c_x) - 33'(a_x);
          f[1] <= 33'(c_y) - 33'(a_y);
          f[2] <= 33'(c_z) - 33'(a_z);
          for (int j = 0; j < 3; j++) begin
            cr[j] <= '0;
            nrm[j] <= '0;
          end
          step <= '0;
          dj <= '0;
          first_index <= INDEX_W'(triangle_count) * INDEX_W'(3);
          status <= (triangle_count >= max_triangles) ? STATUS_REJECTED
                  : STATUS_APPENDED;
        end
      end
      ST_CROSS: begin
        if (step == 4'd6) begin
          for (int j = 0; j < 3; j++) begin
            neg[j] <= cr[j][CROSS_W-1];
            mag[j] <= cr[j][CROSS_W-1] ? -cr[j] : cr[j];
          end
        end else begin
          if (sub_p) cr[sel_c] <= cr[sel_c] - CROSS_W'(prod);
          else cr[sel_c] <= cr[sel_c] + CROSS_W'(prod);
        end
        step <= step + 1'b1;
      end
      ST_CHECK: begin
        if (tiny_cross && sq_small <= 34'(min_normal_length * min_normal_length))
          status <= STATUS_DEGENERATE;
        for (int j = 0; j < 3; j++) u[j] <= UVAL_W'(mag[j] >> shamt);
        sum <= '0;
        step <= '0;
      end
      ST_SUMSQ: begin
        // accumulate u0^2 + u1^2 + u2^2 on the shared multiplier
        if (step != 4'd3) begin
          sum <= sum + SUM_W'(prod);
          step <= step + 1'b1;
        end
      end
      ST_SQRT: begin
        if (ustat.done) len <= (u_res == '0) ? LEN_W'(1) : LEN_W'(u_res);
      end
      ST_DIV: begin
        if (ustat.done) begin
          nrm[dj] <= neg[dj] ? -NORMAL_W'(q) : NORMAL_W'(q);
          dj <= dj + 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  tnb_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (uctrl),
    .sqrt_in (sum),
    .num_in  (uctrl.sqrt_start ? '0 : ((state == ST_SQRT) ? (SUM_W'(u[0])
               << NORMAL_FRAC_BITS) + SUM_W'((u_res == '0 ? 64'd1 : u_res) >> 1)
               : (SUM_W'(u[dj + 1'b1]) << NORMAL_FRAC_BITS) + SUM_W'(len >> 1))),
    .den_in  ((state == ST_SQRT) ? ((u_res == '0) ? LEN_W'(1) : LEN_W'(u_res)) : len),
    .stat    (ustat),
    .result  (u_res)
  );

  assign normal_x = nrm[0];
  assign normal_y = nrm[1];
  assign normal_z = nrm[2];
  assign box_min_x = bmin[0];
  assign box_min_y = bmin[1];
  assign box_min_z = bmin[2];
  assign box_max_x = bmax[0];
  assign box_max_y = bmax[1];
  assign box_max_z = bmax[2];

  logic unused_ok;
  assign unused_ok = ustat.busy;

endmodule
